### hdl/itp_pkg.sv
`default_nettype none

package itp_pkg;

  typedef logic [2:0] op_code_t;
  typedef logic [1:0] err_code_t;
  typedef logic [1:0] prec_t;

  localparam int STACK_DEPTH_DEF = 16;

  // Operator codes as stored on the stack
  localparam op_code_t OP_NONE  = 3'd0;
  localparam op_code_t OP_ADD   = 3'd1;
  localparam op_code_t OP_SUB   = 3'd2;
  localparam op_code_t OP_MUL   = 3'd3;
  localparam op_code_t OP_DIV   = 3'd4;
  localparam op_code_t OP_POW   = 3'd5;
  localparam op_code_t OP_OPEN  = 3'd6;
  localparam op_code_t OP_CLOSE = 3'd7;

  localparam err_code_t ERR_NONE     = 2'd0;
  localparam err_code_t ERR_OVERFLOW = 2'd1;
  localparam err_code_t ERR_CLOSE    = 2'd2;
  localparam err_code_t ERR_OPEN     = 2'd3;

  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  function automatic op_code_t classify(input logic [7:0] ch);
    op_code_t c;
    case (ch)
      CH_ADD:   c = OP_ADD;
      CH_SUB:   c = OP_SUB;
      CH_MUL:   c = OP_MUL;
      CH_DIV:   c = OP_DIV;
      CH_POW:   c = OP_POW;
      CH_OPEN:  c = OP_OPEN;
      CH_CLOSE: c = OP_CLOSE;
      default:  c = OP_NONE;
    endcase
    return c;
  endfunction

  function automatic prec_t prec(input op_code_t c);
    prec_t p;
    case (c)
      OP_POW:         p = 2'd3;
      OP_MUL, OP_DIV: p = 2'd2;
      default:        p = 2'd1;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] code_char(input op_code_t c);
    logic [7:0] ch;
    case (c)
      OP_ADD:   ch = CH_ADD;
      OP_SUB:   ch = CH_SUB;
      OP_MUL:   ch = CH_MUL;
      OP_DIV:   ch = CH_DIV;
      OP_POW:   ch = CH_POW;
      OP_OPEN:  ch = CH_OPEN;
      OP_CLOSE: ch = CH_CLOSE;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### hdl/itp_ram.sv
`default_nettype none

module itp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/infix_to_postfix_converter.sv
`default_nettype none
// An operand item passes the accepted-character register, the pending slot and
// the output register on its way to out_tvalid. A new character is taken only
// when idle: after the last one, its pops and, if final, the stack flush.
// The operator stack lives in a RAM with a registered read port.
// Reset (rst_n low, synchronous) empties the stack and clears the error latch;
// the RAM itself is not cleared, since only entries below the count are read.

module infix_to_postfix_converter
#(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic       in_tlast,   // is_final
  // result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_symbol
  output logic [2:0]      out_tuser,  // [0] has_symbol, [2:1] error
  output logic            out_tlast   // end_of_expression
);

  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);  // count holds 0..STACK_DEPTH
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_FLUSH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  err_code_t        err_r, err_nxt;

  // accepted character
  logic [7:0]       sym_r, sym_nxt;
  op_code_t         code_r, code_nxt;
  logic             fin_r, fin_nxt;

  // Pending slot: the newest result item. It is held back while the current
  // step is final, since only at the end is it known to be the last one.
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_sym_r, pend_sym_nxt;
  logic             pend_has_r, pend_has_nxt;
  logic             pend_end_r, pend_end_nxt;
  err_code_t        pend_err_r, pend_err_nxt;
  logic             pend_seal_r, pend_seal_nxt;

  // output register
  logic             out_v_r, out_v_nxt;
  logic [7:0]       out_sym_r, out_sym_nxt;
  logic             out_has_r, out_has_nxt;
  logic             out_end_r, out_end_nxt;
  err_code_t        out_err_r, out_err_nxt;

  // stack RAM and write forwarding
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  op_code_t         ram_rdata;
  logic             fwd_r, fwd_nxt;
  op_code_t         fwd_data_r;
  op_code_t         top_code;

  // per-cycle action intents
  logic             emit_req;
  logic [7:0]       emit_sym;
  logic             pop_req;
  logic             push_req;
  logic             seal_req;
  err_code_t        latch_req;
  logic             go;
  logic             can_adv;
  logic             drain;
  logic             have;
  logic             full;
  state_t           after_proc;

  itp_ram #(
    .WIDTH ($bits(op_code_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (code_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Top of stack: RAM output, or the code just pushed onto that entry
  assign top_code = fwd_r ? fwd_data_r : ram_rdata;

  assign have       = (count_r != '0);
  assign full       = (count_r == CW'(STACK_DEPTH));
  assign can_adv    = !out_v_r || out_tready;
  assign after_proc = fin_r ? ST_FLUSH : ST_IDLE;

  // Decide this cycle's single stack action
  always_comb begin
    emit_req  = 1'b0;
    emit_sym  = sym_r;
    pop_req   = 1'b0;
    push_req  = 1'b0;
    seal_req  = 1'b0;
    latch_req = ERR_NONE;
    state_nxt = state_r;
    sym_nxt   = sym_r;
    code_nxt  = code_r;
    fin_nxt   = fin_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sym_nxt   = in_tdata;
          code_nxt  = classify(in_tdata);
          fin_nxt   = in_tlast;
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        case (code_r)
          OP_NONE: begin
            // operand: pass straight out
            emit_req  = 1'b1;
            state_nxt = after_proc;
          end
          OP_OPEN: begin
            push_req  = 1'b1;
            state_nxt = after_proc;
          end
          OP_CLOSE: begin
            if (have && top_code != OP_OPEN) begin
              emit_req = 1'b1;
              emit_sym = code_char(top_code);
              pop_req  = 1'b1;
            end else if (have) begin
              // drop the matching open paren
              pop_req   = 1'b1;
              state_nxt = after_proc;
            end else begin
              latch_req = ERR_CLOSE;
              state_nxt = after_proc;
            end
          end
          default: begin
            if (have && top_code != OP_OPEN && prec(top_code) >= prec(code_r)) begin
              emit_req = 1'b1;
              emit_sym = code_char(top_code);
              pop_req  = 1'b1;
            end else begin
              push_req  = 1'b1;
              state_nxt = after_proc;
            end
          end
        endcase
      end
      ST_FLUSH: begin
        if (have) begin
          pop_req = 1'b1;
          if (top_code == OP_OPEN) begin
            latch_req = ERR_OPEN;
          end else begin
            emit_req = 1'b1;
            emit_sym = code_char(top_code);
          end
        end else begin
          seal_req  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // An emit waits until the pending slot can take the item; the close of
    // the run waits until an item left from an earlier character moves on
    if (emit_req) begin
      go = !pend_v_r || can_adv;
    end else if (seal_req) begin
      go = !(pend_v_r && pend_seal_r);
    end else begin
      go = 1'b1;
    end
    if (!go) begin
      state_nxt = state_r;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // Stack bookkeeping, error latch and RAM addressing
  always_comb begin
    count_nxt = count_r;
    err_nxt   = err_r;
    ram_we    = 1'b0;
    ram_waddr = AW'(count_r);

    if (go) begin
      if (pop_req) begin
        count_nxt = count_r - 1'b1;
      end
      if (push_req) begin
        if (full) begin
          if (err_r == ERR_NONE) begin
            err_nxt = ERR_OVERFLOW;
          end
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      if (latch_req != ERR_NONE && err_r == ERR_NONE) begin
        err_nxt = latch_req;
      end
      if (seal_req) begin
        // the expression closes here; start the next one clean
        err_nxt = ERR_NONE;
      end
    end

    // read the entry that will be on top next cycle
    ram_raddr = (count_nxt == '0) ? '0 : AW'(count_nxt - 1'b1);
    fwd_nxt   = ram_we && (ram_waddr == ram_raddr);
  end

  // Pending slot and output register
  always_comb begin
    drain = pend_v_r && can_adv && (pend_seal_r || (emit_req && go));

    out_v_nxt   = out_v_r;
    out_sym_nxt = out_sym_r;
    out_has_nxt = out_has_r;
    out_end_nxt = out_end_r;
    out_err_nxt = out_err_r;
    if (drain) begin
      out_v_nxt   = 1'b1;
      out_sym_nxt = pend_sym_r;
      out_has_nxt = pend_has_r;
      out_end_nxt = pend_end_r;
      out_err_nxt = pend_err_r;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end

    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    pend_has_nxt  = pend_has_r;
    pend_end_nxt  = pend_end_r;
    pend_err_nxt  = pend_err_r;
    pend_seal_nxt = pend_seal_r;
    if (emit_req && go) begin
      pend_v_nxt    = 1'b1;
      pend_sym_nxt  = emit_sym;
      pend_has_nxt  = 1'b1;
      pend_end_nxt  = 1'b0;
      pend_err_nxt  = err_r;
      pend_seal_nxt = !fin_r;
    end else if (seal_req && go) begin
      // mark the last item, or make an empty end item if none is held
      if (!pend_v_r) begin
        pend_sym_nxt = 8'h00;
        pend_has_nxt = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_end_nxt  = 1'b1;
      pend_err_nxt  = err_r;
      pend_seal_nxt = 1'b1;
    end else if (drain) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      err_r       <= ERR_NONE;
      pend_v_r    <= 1'b0;
      pend_seal_r <= 1'b0;
      out_v_r     <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_seal_r <= pend_seal_nxt;
      out_v_r     <= out_v_nxt;
      fwd_r       <= fwd_nxt;
    end
    sym_r      <= sym_nxt;
    code_r     <= code_nxt;
    fin_r      <= fin_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_has_r <= pend_has_nxt;
    pend_end_r <= pend_end_nxt;
    pend_err_r <= pend_err_nxt;
    out_sym_r  <= out_sym_nxt;
    out_has_r  <= out_has_nxt;
    out_end_r  <= out_end_nxt;
    out_err_r  <= out_err_nxt;
    fwd_data_r <= code_r;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = {out_err_r, out_has_r};
  assign out_tlast  = out_end_r;

endmodule

`default_nettype wire
